/* rtl/plav_pkg.sv */
// Package for the power-law Arrhenius viscosity pipeline.
// Holds widths, register indexes, status codes and the exp2 root table builder.
// No dependencies.
package plav_pkg;

  localparam int DATA_W  = 32;  // strain rate, temperature, E, R, Q1.31 mantissas
  localparam int VISC_W  = 48;  // Q16.32 viscosity, k and limits
  localparam int INDEX_W = 20;  // Q4.16 flow index
  localparam int FRAC_W  = 16;  // log domain fraction bits
  localparam int LOG_W   = 21;  // signed Q5.16 log2 of the strain rate
  localparam int SLOPE_W = 26;  // signed (n-1)*log2(s)
  localparam int EXPO_W  = 18;  // signed integer part of the exponent
  localparam int CFG_IDX_W = 3;

  localparam logic [VISC_W-1:0]  K_RESET     = 48'h0001_0000_0000;
  localparam logic [INDEX_W-1:0] N_RESET     = 20'h1_0000;
  localparam logic [VISC_W-1:0]  FLOOR_RESET = '0;
  localparam logic [VISC_W-1:0]  CEIL_RESET  = '1;
  localparam logic [DATA_W-1:0]  E_RESET     = '0;
  localparam logic [DATA_W-1:0]  R_RESET     = 32'd139488682;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic signed [LOG_W-1:0] ONE_Q16 = 21'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K     = 3'd0,
    REG_N     = 3'd1,
    REG_FLOOR = 3'd2,
    REG_CEIL  = 3'd3,
    REG_E     = 3'd4,
    REG_R     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FLOOR = 2'd1,
    ST_CEIL  = 2'd2
  } clamp_t;

  // floor integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-(idx+1)) in Q1.31, by repeated square roots from 2^63
  function automatic logic [DATA_W-1:0] root_entry(input int idx);
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 1; j < 16; j++) begin
      if (j <= idx) r = isqrt64(r << 31);
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

/* rtl/plav_log2.sv */
// log2 of the strain rate: normalise, then sixteen squaring stages, one fraction bit each.
// Depends on plav_pkg. Carries a side word alongside.
module plav_log2 import plav_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [DATA_W-1:0]       strain,
  input  logic [SideW-1:0]        side_in,
  output logic                    out_valid,
  output logic signed [LOG_W-1:0] log_val,
  output logic [SideW-1:0]        side_out
);

  localparam int NSTEP = FRAC_W;

  logic [DATA_W-1:0] s1;
  logic [4:0]        msb;
  logic [DATA_W-1:0] x0;

  logic              vr [0:NSTEP];
  logic [DATA_W-1:0] xr [0:NSTEP];
  logic [4:0]        pr [0:NSTEP];
  logic [FRAC_W-1:0] fr [0:NSTEP];
  logic [SideW-1:0]  sr [0:NSTEP];

  always_comb begin
    s1  = (strain == '0) ? 32'd1 : strain;
    msb = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (s1[i]) msb = i[4:0];
    end
    x0 = s1 << (5'd31 - msb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
    if (en) begin
      xr[0] <= x0;
      pr[0] <= msb;
      fr[0] <= '0;
      sr[0] <= side_in;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'b0, xr[g]} * {32'b0, xr[g]};
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[g+1] <= 1'b0;
      end else if (en) begin
        vr[g+1] <= vr[g];
      end
      if (en) begin
        // halve back into [1,2) when the square reached 2
        xr[g+1] <= t[32] ? t[32:1] : t[31:0];
        fr[g+1] <= {fr[g][FRAC_W-2:0], t[32]};
        pr[g+1] <= pr[g];
        sr[g+1] <= sr[g];
      end
    end
  end

  assign out_valid = vr[NSTEP];
  assign log_val   = {~pr[NSTEP][4], pr[NSTEP][3:0], fr[NSTEP]};
  assign side_out  = sr[NSTEP];

endmodule

/* rtl/plav_div.sv */
// Arrhenius quotient q = E*2^48/(R*T): product stage, overflow check, 32 restoring steps.
// Depends on plav_pkg. Carries a side word alongside.
module plav_div import plav_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DATA_W-1:0] energy,
  input  logic [DATA_W-1:0] gas,
  input  logic [DATA_W-1:0] temp,
  input  logic [SideW-1:0]  side_in,
  output logic              out_valid,
  output logic [DATA_W-1:0] quot,
  output logic              over,
  output logic [SideW-1:0]  side_out
);

  localparam int NSTEP = DATA_W;

  logic              v0;
  logic [63:0]       d0;
  logic [DATA_W-1:0] e0;
  logic [SideW-1:0]  s0;

  logic              vr [0:NSTEP];
  logic [63:0]       dr [0:NSTEP];
  logic [63:0]       rr [0:NSTEP];
  logic [DATA_W-1:0] qr [0:NSTEP];
  logic              or_ [0:NSTEP];
  logic [SideW-1:0]  sr [0:NSTEP];

  logic [63:0] num;
  assign num = {16'b0, e0, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      vr[0] <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      vr[0] <= v0;
    end
    if (en) begin
      d0 <= {32'b0, gas} * {32'b0, temp};
      e0 <= energy;
      s0 <= side_in;
      // any quotient bit at 2^32 or above, or a zero divisor, saturates
      or_[0] <= (num >= d0);
      dr[0]  <= d0;
      rr[0]  <= num;
      qr[0]  <= '0;
      sr[0]  <= s0;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;
    assign sh   = {rr[g], 1'b0};
    assign diff = sh - {1'b0, dr[g]};
    assign ge   = sh >= {1'b0, dr[g]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[g+1] <= 1'b0;
      end else if (en) begin
        vr[g+1] <= vr[g];
      end
      if (en) begin
        rr[g+1]  <= ge ? diff[63:0] : sh[63:0];
        qr[g+1]  <= {qr[g][DATA_W-2:0], ge};
        dr[g+1]  <= dr[g];
        or_[g+1] <= or_[g];
        sr[g+1]  <= sr[g];
      end
    end
  end

  assign out_valid = vr[NSTEP];
  assign quot      = qr[NSTEP];
  assign over      = or_[NSTEP];
  assign side_out  = sr[NSTEP];

endmodule

/* rtl/plav_exp2.sv */
// 2^yf in Q1.31 from the fraction bits: one table multiply per stage.
// Depends on plav_pkg (root table). Carries a side word alongside.
module plav_exp2 import plav_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FRAC_W-1:0] frac,
  input  logic [SideW-1:0]  side_in,
  output logic              out_valid,
  output logic [DATA_W-1:0] mant,
  output logic [SideW-1:0]  side_out
);

  localparam int NSTEP = FRAC_W;

  logic              vr [0:NSTEP];
  logic [DATA_W-1:0] fr [0:NSTEP];
  logic [FRAC_W-1:0] yr [0:NSTEP];
  logic [SideW-1:0]  sr [0:NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
    if (en) begin
      fr[0] <= 32'h8000_0000;
      yr[0] <= frac;
      sr[0] <= side_in;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_mul
    localparam logic [DATA_W-1:0] ROOT = root_entry(g);
    logic [63:0] prod;
    assign prod = {32'b0, fr[g]} * {32'b0, ROOT};
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[g+1] <= 1'b0;
      end else if (en) begin
        vr[g+1] <= vr[g];
      end
      if (en) begin
        fr[g+1] <= yr[g][FRAC_W-1-g] ? prod[62:31] : fr[g];
        yr[g+1] <= yr[g];
        sr[g+1] <= sr[g];
      end
    end
  end

  assign out_valid = vr[NSTEP];
  assign mant      = fr[NSTEP];
  assign side_out  = sr[NSTEP];

endmodule

/* rtl/power_law_arrhenius_viscosity_core.sv */
// Power-law viscosity with Arrhenius factor, fully pipelined, one cell per request.
// Throughput: one request per cycle while the output is not stalled. The pipeline holds
// the 16 log2 squaring stages, the 32-step quotient and the 16 exp2 multiplies.
// A stalled output holds the whole pipeline. Synchronous reset clears all valid bits
// and loads the register defaults. Depends on plav_pkg, plav_log2, plav_div, plav_exp2.
module power_law_arrhenius_viscosity_core import plav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    strain_rate,
  input  logic [DATA_W-1:0]    temperature,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VISC_W-1:0]    viscosity,
  output logic [1:0]           clamp_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VISC_W-1:0]    cfg_data
);

  logic [VISC_W-1:0]  consistency_k;
  logic [INDEX_W-1:0] flow_index_n;
  logic [VISC_W-1:0]  viscosity_floor;
  logic [VISC_W-1:0]  viscosity_ceiling;
  logic [DATA_W-1:0]  activation_energy;
  logic [DATA_W-1:0]  gas_constant;

  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      consistency_k     <= K_RESET;
      flow_index_n      <= N_RESET;
      viscosity_floor   <= FLOOR_RESET;
      viscosity_ceiling <= CEIL_RESET;
      activation_energy <= E_RESET;
      gas_constant      <= R_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_K:     consistency_k     <= cfg_data;
        REG_N:     flow_index_n      <= cfg_data[INDEX_W-1:0];
        REG_FLOOR: viscosity_floor   <= cfg_data;
        REG_CEIL:  viscosity_ceiling <= cfg_data;
        REG_E:     activation_energy <= cfg_data[DATA_W-1:0];
        REG_R:     gas_constant      <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // log2 of the strain rate
  logic                    lg_valid;
  logic signed [LOG_W-1:0] lg_val;
  logic [DATA_W-1:0]       lg_temp;

  plav_log2 #(.SideW(DATA_W)) u_log2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .strain(strain_rate), .side_in(temperature),
    .out_valid(lg_valid), .log_val(lg_val), .side_out(lg_temp)
  );

  // stage A: a = floor((n-1) * L / 2^16)
  logic signed [LOG_W-1:0]     n_m1;
  logic signed [2*LOG_W-1:0]   a_full;
  logic                        a_valid;
  logic signed [SLOPE_W-1:0]   a_val;
  logic [DATA_W-1:0]           a_temp;

  assign n_m1   = $signed({flow_index_n[INDEX_W-1], flow_index_n}) - ONE_Q16;
  assign a_full = n_m1 * lg_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= lg_valid;
    end
    if (en) begin
      a_val  <= a_full[2*LOG_W-1:FRAC_W];
      a_temp <= lg_temp;
    end
  end

  // Arrhenius quotient
  logic                      dv_valid;
  logic [DATA_W-1:0]         dv_q;
  logic                      dv_over;
  logic [SLOPE_W-1:0]        dv_a;

  plav_div #(.SideW(SLOPE_W)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_valid), .energy(activation_energy), .gas(gas_constant), .temp(a_temp),
    .side_in(a_val),
    .out_valid(dv_valid), .quot(dv_q), .over(dv_over), .side_out(dv_a)
  );

  // stage B: b = q * log2(e)
  logic [63:0]               b_prod;
  logic                      b_valid;
  logic [32:0]               b_val;
  logic [SLOPE_W-1:0]        b_a;
  logic                      b_over;

  assign b_prod = {32'b0, dv_q} * {33'b0, LOG2E_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= dv_valid;
    end
    if (en) begin
      b_val  <= b_prod[62:30];
      b_a    <= dv_a;
      b_over <= dv_over;
    end
  end

  // stage C: y = a + b, split into integer and fraction
  logic [33:0]       y_sum;
  logic              c_valid;
  logic [EXPO_W-1:0] c_yi;
  logic [FRAC_W-1:0] c_yf;
  logic              c_over;

  assign y_sum = {{8{b_a[SLOPE_W-1]}}, b_a} + {1'b0, b_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_yi   <= y_sum[33:FRAC_W];
      c_yf   <= y_sum[FRAC_W-1:0];
      c_over <= b_over;
    end
  end

  // 2^yf
  logic                 ex_valid;
  logic [DATA_W-1:0]    ex_f;
  logic [EXPO_W:0]      ex_side;

  plav_exp2 #(.SideW(EXPO_W + 1)) u_exp2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .frac(c_yf), .side_in({c_over, c_yi}),
    .out_valid(ex_valid), .mant(ex_f), .side_out(ex_side)
  );

  // stage D: partial products of k * 2^yf
  logic              d_valid;
  logic [63:0]       d_hi;
  logic [47:0]       d_lo;
  logic [EXPO_W-1:0] d_yi;
  logic              d_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= ex_valid;
    end
    if (en) begin
      d_hi   <= {32'b0, consistency_k[47:16]} * {32'b0, ex_f};
      d_lo   <= {32'b0, consistency_k[15:0]} * {16'b0, ex_f};
      d_yi   <= ex_side[EXPO_W-1:0];
      d_over <= ex_side[EXPO_W];
    end
  end

  // stage E: m = floor(k * 2^yf / 2^31)
  logic [48:0]       low_sum;
  logic [48:0]       m_next;
  logic              e_valid;
  logic [48:0]       e_m;
  logic [EXPO_W-1:0] e_yi;
  logic              e_over;

  assign low_sum = {18'b0, d_hi[14:0], 16'b0} + {1'b0, d_lo};
  assign m_next  = d_hi[63:15] + {31'b0, low_sum[48:31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_m    <= m_next;
      e_yi   <= d_yi;
      e_over <= d_over;
    end
  end

  // stage F: scale by 2^yi
  logic [96:0]       wide;
  logic [EXPO_W-1:0] nsh;
  logic [48:0]       rsh;
  logic [VISC_W-1:0] f_v_next;
  logic              f_over_next;
  logic              f_valid;
  logic [VISC_W-1:0] f_v;
  logic              f_over;

  always_comb begin
    wide        = {48'b0, e_m} << e_yi[5:0];
    nsh         = -e_yi;
    rsh         = e_m >> nsh[5:0];
    f_v_next    = '0;
    f_over_next = e_over;
    if (!e_over && e_m != '0) begin
      if (!e_yi[EXPO_W-1]) begin
        if ($signed(e_yi) > 18'sd48 || wide[96:48] != '0) begin
          f_over_next = 1'b1;
        end else begin
          f_v_next = wide[47:0];
        end
      end else if (nsh[EXPO_W-1:6] == '0) begin
        f_v_next = rsh[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_v    <= f_v_next;
      f_over <= f_over_next;
    end
  end

  // output register: ceiling cut first, floor raise after it
  logic [VISC_W-1:0] g_v;
  clamp_t            g_st;

  always_comb begin
    g_v  = f_v;
    g_st = ST_OK;
    if (f_over || f_v > viscosity_ceiling) begin
      g_v  = viscosity_ceiling;
      g_st = ST_CEIL;
    end
    if (g_v < viscosity_floor) begin
      g_v  = viscosity_floor;
      g_st = ST_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_valid;
    end
    if (en) begin
      viscosity    <= g_v;
      clamp_status <= g_st;
    end
  end

  a_floor_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_status == ST_FLOOR |-> viscosity == viscosity_floor)
    else $error("floor status without floor value");

  a_ceil_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_status == ST_CEIL |-> viscosity == viscosity_ceiling
      && viscosity_ceiling >= viscosity_floor)
    else $error("ceiling status with wrong value");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_status == ST_OK |->
      viscosity >= viscosity_floor && viscosity <= viscosity_ceiling)
    else $error("unclamped result outside limits");

endmodule
